FILE: rtl/core/plsc_pkg.sv
// Shared types and constants of the light and shade controller.
// Holds field widths, register codes, reset values and the config struct.
// No dependencies.
package plsc_pkg;

    // Fixed-point position of the Q8.8 gains
    localparam int GAIN_FRACTION_BITS = 8;

    // Field widths
    localparam int LUX_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int LIM_W   = 15;
    localparam int DUTY_W  = 16;
    localparam int ANG_W   = 12;
    localparam int STEP_W  = 8;
    localparam int POS_W   = 14;
    localparam int ERR_W   = LUX_W + 1;   // setpoint - measurement
    localparam int SUM_W   = 16;          // clamped error sum
    localparam int DER_W   = ERR_W + 1;   // change in error
    localparam int ACC_W   = 36;          // exact drive sum

    // Stream and config port widths
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 40;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN        = 8'd0,
        REG_KI_GAIN        = 8'd1,
        REG_KD_GAIN        = 8'd2,
        REG_INTEGRAL_LIMIT = 8'd3,
        REG_DUTY_MAX       = 8'd4,
        REG_ANGLE_MAX      = 8'd5,
        REG_ANGLE_MIN      = 8'd6,
        REG_STEP_SIZE      = 8'd7
    } cfg_idx_t;

    // Reset values
    localparam logic [GAIN_W-1:0] KP_RESET        = 16'd1190;
    localparam logic [GAIN_W-1:0] KI_RESET        = 16'd768;
    localparam logic [GAIN_W-1:0] KD_RESET        = 16'd128;
    localparam logic [LIM_W-1:0]  LIM_RESET       = 15'd10000;
    localparam logic [DUTY_W-1:0] DUTY_MAX_RESET  = 16'd10000;
    localparam logic [ANG_W-1:0]  ANGLE_MAX_RESET = 12'd875;
    localparam logic [ANG_W-1:0]  ANGLE_MIN_RESET = 12'd20;
    localparam logic [STEP_W-1:0] STEP_RESET      = 8'd10;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_gain;
        logic [GAIN_W-1:0] kd_gain;
        logic [LIM_W-1:0]  integral_limit;
        logic [DUTY_W-1:0] duty_max;
        logic [ANG_W-1:0]  angle_max;
        logic [ANG_W-1:0]  angle_min;
        logic [STEP_W-1:0] step_size;
    } cfg_t;

endpackage

FILE: rtl/core/plsc_cfg.sv
// Configuration register bank of the light and shade controller.
// Decodes indexed writes and masks each value to its register width.
// Depends on plsc_pkg.
module plsc_cfg
    import plsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always take a write word
    assign cfg_ready = 1'b1;
    assign cfg           = cfg_reg;

    // Decode the write; ignore indexes beyond the list
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                REG_KP_GAIN:        cfg_next.kp_gain        = cfg_data[GAIN_W-1:0];
                REG_KI_GAIN:        cfg_next.ki_gain        = cfg_data[GAIN_W-1:0];
                REG_KD_GAIN:        cfg_next.kd_gain        = cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_data[LIM_W-1:0];
                REG_DUTY_MAX:       cfg_next.duty_max       = cfg_data[DUTY_W-1:0];
                REG_ANGLE_MAX:      cfg_next.angle_max      = cfg_data[ANG_W-1:0];
                REG_ANGLE_MIN:      cfg_next.angle_min      = cfg_data[ANG_W-1:0];
                REG_STEP_SIZE:      cfg_next.step_size      = cfg_data[STEP_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers, load reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_gain        <= KP_RESET;
            cfg_reg.ki_gain        <= KI_RESET;
            cfg_reg.kd_gain        <= KD_RESET;
            cfg_reg.integral_limit <= LIM_RESET;
            cfg_reg.duty_max       <= DUTY_MAX_RESET;
            cfg_reg.angle_max      <= ANGLE_MAX_RESET;
            cfg_reg.angle_min      <= ANGLE_MIN_RESET;
            cfg_reg.step_size      <= STEP_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/core/pid_light_and_shade_control.sv
// Top level of the light and shade controller: PID lamp drive and shade stepper.
// Instantiates plsc_cfg for the register bank; depends on plsc_pkg.
//
// Usage:
//   s_ channel: one word per sample, setpoint and measurement in lux.
//   m_ channel: one word per sample, the lamp duty and the stepper command.
//   cfg_ channel: indexed register writes, taken in every cycle; write only
//   while no sample is in flight.
// Throughput: one sample per cycle while the receiver does not stall. Error,
// clamped error sum, derivative and the shade stepper are settled in the
// accept cycle, the three gain products in the second stage, the drive sum
// and duty clamp in the third.
// Each stage moves on when its successor is empty or moving, so s_tready
// stays high while the output word waits and a free slot is left in the pipe;
// a stalled receiver fills the three stages and then drops s_tready.
// Reset clears the error sum, last error, shade angle and all valid flags,
// and loads the register reset values.
module pid_light_and_shade_control
    import plsc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [15:0] setpoint, [31:16] measurement
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] duty, [16] step_issued, [17] step_opening, [18] shade_closing,
    // [32:19] shade_angle, [39:33] zero
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    plsc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Controller state
    logic signed [SUM_W-1:0] error_sum_reg;
    logic signed [ERR_W-1:0] last_error_reg;
    logic signed [POS_W-1:0] position_reg;

    // Stage 1 registers
    logic                    v1_reg;
    logic signed [ERR_W-1:0] err1_reg;
    logic signed [SUM_W-1:0] sum1_reg;
    logic signed [DER_W-1:0] der1_reg;
    logic [2:0]              flags1_reg;   // issued, opening, closing
    logic signed [POS_W-1:0] pos1_reg;

    // Stage 2 registers
    logic                          v2_reg;
    logic signed [GAIN_W+ERR_W:0]  prod_p_reg;
    logic signed [GAIN_W+SUM_W:0]  prod_i_reg;
    logic signed [GAIN_W+DER_W:0]  prod_d_reg;
    logic [2:0]                    flags2_reg;
    logic signed [POS_W-1:0]       pos2_reg;

    // Output register
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;

    // Stage enables: advance when the next stage is empty or advancing
    logic en1, en2, en3;
    assign en3      = !m_tvalid_reg || m_tready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    logic accept;
    assign accept = s_tvalid && en1;

    // Error, anti-windup sum and derivative
    logic [LUX_W-1:0]        sp, meas;
    logic signed [ERR_W-1:0] err;
    logic signed [DER_W:0]   sum_raw, lim_pos, lim_neg;
    logic signed [SUM_W-1:0] sum_c;
    logic signed [DER_W-1:0] der;

    assign sp   = s_tdata[LUX_W-1:0];
    assign meas = s_tdata[2*LUX_W-1:LUX_W];

    always_comb begin
        err     = $signed({1'b0, sp}) - $signed({1'b0, meas});
        sum_raw = (DER_W+1)'(error_sum_reg) + (DER_W+1)'(err);
        lim_pos = $signed({{(DER_W+1-LIM_W){1'b0}}, cfg.integral_limit});
        lim_neg = -lim_pos;
        if (sum_raw > lim_pos) begin
            sum_c = lim_pos[SUM_W-1:0];
        end else if (sum_raw < lim_neg) begin
            sum_c = lim_neg[SUM_W-1:0];
        end else begin
            sum_c = sum_raw[SUM_W-1:0];
        end
        der = DER_W'(err) - DER_W'(last_error_reg);
    end

    // Shade stepper: test the bound before the move
    logic                    closing, issued, opening;
    logic signed [POS_W-1:0] ang_max_s, ang_min_s, step_s, pos_new;

    always_comb begin
        closing   = (meas >= sp);
        ang_max_s = $signed({{(POS_W-ANG_W){1'b0}}, cfg.angle_max});
        ang_min_s = $signed({{(POS_W-ANG_W){1'b0}}, cfg.angle_min});
        step_s    = $signed({{(POS_W-STEP_W){1'b0}}, cfg.step_size});
        issued    = 1'b0;
        opening   = 1'b0;
        pos_new   = position_reg;
        if (closing) begin
            if (position_reg <= ang_max_s) begin
                issued  = 1'b1;
                pos_new = position_reg + step_s;
            end
        end else begin
            if (position_reg >= ang_min_s) begin
                issued  = 1'b1;
                opening = 1'b1;
                pos_new = position_reg - step_s;
            end
        end
    end

    // Stage 1: update the state and register the terms
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            position_reg   <= '0;
        end else begin
            if (en1) begin
                v1_reg <= s_tvalid;
            end
            if (accept) begin
                error_sum_reg  <= sum_c;
                last_error_reg <= err;
                position_reg   <= pos_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            err1_reg   <= err;
            sum1_reg   <= sum_c;
            der1_reg   <= der;
            flags1_reg <= {issued, opening, closing};
            pos1_reg   <= pos_new;
        end
    end

    // Stage 2: gain products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            prod_p_reg <= $signed({1'b0, cfg.kp_gain}) * err1_reg;
            prod_i_reg <= $signed({1'b0, cfg.ki_gain}) * sum1_reg;
            prod_d_reg <= $signed({1'b0, cfg.kd_gain}) * der1_reg;
            flags2_reg <= flags1_reg;
            pos2_reg   <= pos1_reg;
        end
    end

    // Stage 3: drive sum, floor shift and duty clamp
    logic signed [ACC_W-1:0] acc, acc_sh, duty_max_s;
    logic [DUTY_W-1:0]       duty;

    always_comb begin
        acc = ACC_W'(prod_p_reg) + ACC_W'(prod_i_reg) + ACC_W'(prod_d_reg);
        acc_sh     = acc >>> GAIN_FRACTION_BITS;
        duty_max_s = $signed({{(ACC_W-DUTY_W){1'b0}}, cfg.duty_max});
        if (acc[ACC_W-1]) begin
            duty = '0;
        end else if (acc_sh > duty_max_s) begin
            duty = cfg.duty_max;
        end else begin
            duty = acc_sh[DUTY_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en3) begin
            m_tvalid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            m_tdata_reg <= {{(M_DATA_W-DUTY_W-3-POS_W){1'b0}}, pos2_reg,
                            flags2_reg[0], flags2_reg[1], flags2_reg[2], duty};
        end
    end

    // An empty first stage always takes a word
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !v1_reg |-> s_tready)
        else $error("s_tready low with an empty first stage");

    // An accepted word occupies the first stage next cycle
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted word lost");

    // Opening is only reported with an issued move
    a_open_needs_move: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[DUTY_W+1] || m_tdata[DUTY_W]))
        else $error("step_opening without step_issued");

    // Shade angle stays within one step of the 12-bit bounds
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (position_reg >= -14'sd255) && (position_reg <= 14'sd4350))
        else $error("shade angle out of range");

endmodule

FILE: verif/pid_light_and_shade_control_tb.sv
// Self-checking testbench for pid_light_and_shade_control: lamp PID drive and shade stepper.
// Predicts each result word from the lux samples it accepts and checks every field in order.
// Depends on plsc_pkg and the RTL of pid_light_and_shade_control.
module pid_light_and_shade_control_tb;
    import plsc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 7;
    localparam int PIPE_LATENCY     = 3;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TIMEOUT_CYCLES   = 200000;

    localparam logic [CFG_IDX_W-1:0] REG_PAST_END  = REG_STEP_SIZE + 1;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = {CFG_IDX_W{1'b1}};

    // One sample on the s_ channel, setpoint in the low half
    typedef struct packed {
        logic [LUX_W-1:0] measurement;
        logic [LUX_W-1:0] setpoint;
    } lux_sample_t;

    // One result word on the m_ channel, duty in the low bits
    typedef struct packed {
        logic [POS_W-1:0]  shade_angle;
        logic              shade_closing;
        logic              step_opening;
        logic              step_issued;
        logic [DUTY_W-1:0] duty;
    } light_result_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pid_light_and_shade_control dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus and expectation stores
    lux_sample_t   lux_samples_q[$];
    light_result_t due_outputs[$];
    reg_write_t    reg_writes_q[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic recv_hold_start = 1'b0;
    int recv_hold_left = 0;
    int mismatch_count = 0;

    light_result_t seen_word;
    light_result_t due_word;

    // Predictor copy of the register bank
    logic [GAIN_W-1:0] cfg_kp = KP_RESET;
    logic [GAIN_W-1:0] cfg_ki = KI_RESET;
    logic [GAIN_W-1:0] cfg_kd = KD_RESET;
    logic [LIM_W-1:0]  cfg_limit = LIM_RESET;
    logic [DUTY_W-1:0] cfg_duty_max = DUTY_MAX_RESET;
    logic [ANG_W-1:0]  cfg_angle_max = ANGLE_MAX_RESET;
    logic [ANG_W-1:0]  cfg_angle_min = ANGLE_MIN_RESET;
    logic [STEP_W-1:0] cfg_step = STEP_RESET;

    // Predictor copy of the controller state
    int lamp_err_sum = 0;
    int lamp_last_err = 0;
    int shade_pos = 0;

    // Apply one register write, masked to the register's width
    function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_KP_GAIN:        cfg_kp = data[GAIN_W-1:0];
            REG_KI_GAIN:        cfg_ki = data[GAIN_W-1:0];
            REG_KD_GAIN:        cfg_kd = data[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT: cfg_limit = data[LIM_W-1:0];
            REG_DUTY_MAX:       cfg_duty_max = data[DUTY_W-1:0];
            REG_ANGLE_MAX:      cfg_angle_max = data[ANG_W-1:0];
            REG_ANGLE_MIN:      cfg_angle_min = data[ANG_W-1:0];
            REG_STEP_SIZE:      cfg_step = data[STEP_W-1:0];
            default: ;
        endcase
    endfunction

    // Advance the PID and stepper by one sample and return the word it yields
    function automatic light_result_t next_lamp_and_shade(lux_sample_t smp);
        int err;
        int sum;
        int lim;
        int deriv;
        longint drive;
        light_result_t res;
        res = '0;
        err = int'(smp.setpoint) - int'(smp.measurement);
        lim = int'(cfg_limit);
        // anti-windup clamp on the error sum
        sum = lamp_err_sum + err;
        if (sum > lim) sum = lim;
        if (sum < -lim) sum = -lim;
        lamp_err_sum = sum;
        deriv = err - lamp_last_err;
        lamp_last_err = err;
        drive = longint'(cfg_kp) * err + longint'(cfg_ki) * sum + longint'(cfg_kd) * deriv;
        if (drive > 0) begin
            drive = drive >>> GAIN_FRACTION_BITS;
            if (drive > longint'(cfg_duty_max)) drive = longint'(cfg_duty_max);
            res.duty = DUTY_W'(drive);
        end
        // shade stepper: bound is tested before the move
        res.shade_closing = smp.measurement >= smp.setpoint;
        if (res.shade_closing) begin
            if (shade_pos <= int'(cfg_angle_max)) begin
                res.step_issued = 1'b1;
                shade_pos += int'(cfg_step);
            end
        end else if (shade_pos >= int'(cfg_angle_min)) begin
            res.step_issued = 1'b1;
            res.step_opening = 1'b1;
            shade_pos -= int'(cfg_step);
        end
        res.shade_angle = POS_W'(shade_pos);
        return res;
    endfunction

    // Clock
    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Hard limit on run time
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAIL");
        $finish;
    end

    // Sample driver: predict on accept, then offer the next word or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                due_outputs.push_back(next_lamp_and_shade(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (lux_samples_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_tdata  <= lux_samples_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Register write driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                apply_reg_write(cfg_index, cfg_data);
            end
            if (!cfg_valid || cfg_ready) begin
                if (reg_writes_q.size() != 0) begin
                    {cfg_index, cfg_data} <= reg_writes_q.pop_front();
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off counter
    always @(posedge aclk) begin
        if (recv_hold_start) begin
            recv_hold_left <= LONG_HOLD_CYCLES;
        end else if (recv_hold_left != 0) begin
            recv_hold_left <= recv_hold_left - 1;
        end
    end

    // Result monitor: compare each accepted word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen_word = m_tdata[$bits(light_result_t)-1:0];
                if (due_outputs.size() == 0) begin
                    $error("result word %h arrived with no sample pending", m_tdata);
                    mismatch_count++;
                end else begin
                    due_word = due_outputs.pop_front();
                    if (seen_word.duty !== due_word.duty) begin
                        $error("duty: expected %0d, actual %0d", due_word.duty, seen_word.duty);
                        mismatch_count++;
                    end
                    if (seen_word.step_issued !== due_word.step_issued) begin
                        $error("step_issued: expected %0b, actual %0b",
                               due_word.step_issued, seen_word.step_issued);
                        mismatch_count++;
                    end
                    if (seen_word.step_opening !== due_word.step_opening) begin
                        $error("step_opening: expected %0b, actual %0b",
                               due_word.step_opening, seen_word.step_opening);
                        mismatch_count++;
                    end
                    if (seen_word.shade_closing !== due_word.shade_closing) begin
                        $error("shade_closing: expected %0b, actual %0b",
                               due_word.shade_closing, seen_word.shade_closing);
                        mismatch_count++;
                    end
                    if (seen_word.shade_angle !== due_word.shade_angle) begin
                        $error("shade_angle: expected %0d, actual %0d",
                               $signed(due_word.shade_angle), $signed(seen_word.shade_angle));
                        mismatch_count++;
                    end
                end
            end
            m_tready <= recv_hold_left == 0 && !recv_hold_start &&
                        $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    task automatic push_sample(logic [LUX_W-1:0] sp, logic [LUX_W-1:0] meas);
        lux_sample_t smp;
        smp.setpoint = sp;
        smp.measurement = meas;
        lux_samples_q.push_back(smp);
    endtask

    // Random samples, mostly runs that drive the shade one way
    task automatic push_random(int count);
        int left;
        int run;
        int sp;
        int meas;
        left = count;
        while (left > 0) begin
            run = $urandom_range(1, 24);
            if (run > left) run = left;
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    // closing run: measurement at or above setpoint
                    repeat (run) begin
                        sp = $urandom_range(0, 65535);
                        push_sample(sp, $urandom_range(sp, 65535));
                    end
                end
                3, 4, 5: begin
                    // opening run: measurement below setpoint
                    repeat (run) begin
                        meas = $urandom_range(0, 65534);
                        push_sample($urandom_range(meas + 1, 65535), meas);
                    end
                end
                6: begin
                    // small errors around a random level
                    repeat (run) begin
                        sp = $urandom_range(16, 65519);
                        push_sample(sp, sp + $urandom_range(0, 32) - 16);
                    end
                end
                7: begin
                    repeat (run) begin
                        sp = $urandom_range(0, 65535);
                        push_sample(sp, sp);
                    end
                end
                8: begin
                    // rail values mixed with noise
                    repeat (run) begin
                        sp = $urandom_range(0, 2) == 0 ? 0 :
                             ($urandom_range(0, 1) == 0 ? 65535 : $urandom_range(0, 65535));
                        meas = $urandom_range(0, 2) == 0 ? 0 :
                               ($urandom_range(0, 1) == 0 ? 65535 : $urandom_range(0, 65535));
                        push_sample(sp, meas);
                    end
                end
                default: begin
                    repeat (run) push_sample($urandom_range(0, 65535), $urandom_range(0, 65535));
                end
            endcase
            left -= run;
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        reg_write_t wr;
        wr.index = idx;
        wr.data = data;
        reg_writes_q.push_back(wr);
    endtask

    // Hold until every queued register write has gone through
    task automatic commit_regs();
        while (reg_writes_q.size() != 0 || cfg_valid) @(posedge aclk);
    endtask

    task automatic write_random_regs();
        write_reg(REG_KP_GAIN, $urandom_range(0, 65535));
        write_reg(REG_KI_GAIN, $urandom_range(0, 65535));
        write_reg(REG_KD_GAIN, $urandom_range(0, 65535));
        write_reg(REG_INTEGRAL_LIMIT, $urandom_range(0, 65535));
        write_reg(REG_DUTY_MAX, $urandom_range(0, 65535));
        write_reg(REG_ANGLE_MAX, $urandom_range(0, 65535));
        write_reg(REG_ANGLE_MIN, $urandom_range(0, 65535));
        write_reg(REG_STEP_SIZE, $urandom_range(0, 65535));
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct <= send_pct;
        recv_stall_pct <= recv_pct;
        @(posedge aclk);
    endtask

    // Wait until every sample is taken and every word has come back
    task automatic wait_drained();
        while (lux_samples_q.size() != 0 || s_tvalid || due_outputs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (PIPE_LATENCY + 1) @(posedge aclk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings, directed corners, no idling
        set_idling(0, 0);
        push_sample(65535, 0);
        push_sample(0, 0);
        push_sample(65535, 0);
        push_sample(65535, 0);
        push_sample(0, 65535);
        push_sample(0, 65535);
        push_sample(65535, 65535);
        push_sample(1, 0);
        push_sample(0, 1);
        push_sample(32768, 32767);
        push_sample(32767, 32768);
        push_sample(16'h5555, 16'hAAAA);
        push_sample(16'hAAAA, 16'h5555);
        push_sample(100, 100);
        push_sample(200, 150);
        push_sample(200, 250);
        push_sample(40000, 39990);
        push_sample(40000, 39990);
        push_sample(0, 65535);
        push_sample(65535, 1);
        push_random(60);
        wait_drained();

        // Random settings, sender idling
        write_random_regs();
        commit_regs();
        set_idling(68, 0);
        push_random(70);
        wait_drained();

        // Top settings; upper data bits must be masked off
        write_reg(REG_KP_GAIN, 16'hFFFF);
        write_reg(REG_KI_GAIN, 16'hFFFF);
        write_reg(REG_KD_GAIN, 16'hFFFF);
        write_reg(REG_INTEGRAL_LIMIT, 16'hFFFF);
        write_reg(REG_DUTY_MAX, 16'hFFFF);
        write_reg(REG_ANGLE_MAX, 16'hFFFF);
        write_reg(REG_ANGLE_MIN, 16'hF000);
        write_reg(REG_STEP_SIZE, 16'hFFFF);
        commit_regs();
        set_idling(0, 68);
        push_random(80);
        wait_drained();

        // Bottom settings: zero gains, zero limit, zero step, inverted angle window
        write_reg(REG_KP_GAIN, 16'h0000);
        write_reg(REG_KI_GAIN, 16'h0000);
        write_reg(REG_KD_GAIN, 16'h0000);
        write_reg(REG_INTEGRAL_LIMIT, 16'h8000);
        write_reg(REG_DUTY_MAX, 16'h0000);
        write_reg(REG_ANGLE_MAX, 16'hF000);
        write_reg(REG_ANGLE_MIN, 16'h0FFF);
        write_reg(REG_STEP_SIZE, 16'hFF00);
        commit_regs();
        set_idling(26, 26);
        push_random(60);
        wait_drained();

        // Random settings with writes past the register list; long receiver hold
        write_reg($urandom_range(REG_PAST_END, REG_INDEX_TOP), $urandom_range(0, 65535));
        write_random_regs();
        write_reg(REG_PAST_END, $urandom_range(0, 65535));
        write_reg(REG_INDEX_TOP, $urandom_range(0, 65535));
        commit_regs();
        set_idling(0, 0);
        push_random(80);
        recv_hold_start <= 1'b1;
        @(posedge aclk);
        recv_hold_start <= 1'b0;
        wait_drained();

        // Reset values again; sender pauses mid-phase until all results are back
        write_reg(REG_KP_GAIN, KP_RESET);
        write_reg(REG_KI_GAIN, KI_RESET);
        write_reg(REG_KD_GAIN, KD_RESET);
        write_reg(REG_INTEGRAL_LIMIT, LIM_RESET);
        write_reg(REG_DUTY_MAX, DUTY_MAX_RESET);
        write_reg(REG_ANGLE_MAX, ANGLE_MAX_RESET);
        write_reg(REG_ANGLE_MIN, ANGLE_MIN_RESET);
        write_reg(REG_STEP_SIZE, STEP_RESET);
        commit_regs();
        set_idling(68, 68);
        push_random(40);
        wait_drained();
        set_idling(26, 26);
        push_random(40);
        wait_drained();

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
